[hdl/kwts_pkg.sv]
// Shared constants, types and helper functions for the k-mer window table scanner.
package kwts_pkg;

    localparam int KMER_LEN      = 30;
    localparam int TABLE_SLOTS   = 2048;
    localparam int POSITION_BITS = 8;

    localparam int KMER_FIELD_W = 60;
    localparam int KEY_W        = 2 * KMER_LEN;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);
    localparam int COUNT_W      = SLOT_W + 1;
    localparam int CELLS        = 8;
    localparam int LANE_W       = $clog2(CELLS);
    localparam int BANK_DEPTH   = TABLE_SLOTS / CELLS;
    localparam int BANK_AW      = SLOT_W - LANE_W;
    localparam int STEP_W       = COUNT_W - LANE_W;
    localparam int FILL_W       = $clog2(KMER_LEN + 1);
    localparam int POS_W        = POSITION_BITS;
    localparam int INDEX_W      = 11;
    localparam int WPOS_W       = 8;
    localparam int WPOS_MAX     = 255;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;
    typedef logic [LANE_W-1:0]  lane_t;

    // Input item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_BASE   = 1'b1;

    typedef enum logic [1:0] {
        RES_HIT        = 2'd0,
        RES_SUMMARY    = 2'd1,
        RES_INSERT_OK  = 2'd2,
        RES_TABLE_FULL = 2'd3
    } result_kind_t;

    // Read request broadcast to every cell for one scan step.
    typedef struct packed {
        logic       en;
        bank_addr_t addr;
    } rd_req_t;

    // Write request; only the cell whose lane matches stores the key.
    typedef struct packed {
        logic       en;
        lane_t      lane;
        bank_addr_t addr;
        key_t       key;
    } wr_req_t;

    // Lowest matching slot so far for both search keys, passed cell to cell.
    typedef struct packed {
        logic  found_a;
        slot_t slot_a;
        logic  found_b;
        slot_t slot_b;
    } chain_t;

    // Reverse complement of a packed k-mer: base order reversed, each base complemented.
    function automatic key_t revcomp(input key_t v);
        key_t r;
        r = '0;
        for (int i = 0; i < KMER_LEN; i++) begin
            r[2*i +: 2] = ~v[2*(KMER_LEN-1-i) +: 2];
        end
        return r;
    endfunction

endpackage

[hdl/kmer_window_table_scanner.sv]
// Top level of the k-mer window table scanner: control sequencer, read state and the cell row.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------------------
//   input   | in_valid, in_ready  | kind, kmer_value, base_code, read_end
//   output  | out_valid, out_ready| result_kind, entry_index, window_position, first_entry,
//           |                     | final_entry, any_hit, position_overflow, run_last
//
// An insert request or a full-window nucleotide request scans the table with the eight
// cells reading their banks in lock step, one row per cycle; inserts then pass through
// the write states S_WR_A and S_WR_B, and each result goes out through the output register.
// A nucleotide request whose window is not yet full does no table scan.
// Reset clears all control state and the entry count; table contents are never read above
// the entry count, so no clearing pass is needed. A stalled output holds its result while
// the sequencer waits to load the next one.
module kmer_window_table_scanner
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [kwts_pkg::KMER_FIELD_W-1:0]    kmer_value,
    input  logic [1:0]                           base_code,
    input  logic                                 read_end,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           result_kind,
    output logic [kwts_pkg::INDEX_W-1:0]         entry_index,
    output logic [kwts_pkg::WPOS_W-1:0]          window_position,
    output logic [kwts_pkg::INDEX_W-1:0]         first_entry,
    output logic [kwts_pkg::INDEX_W-1:0]         final_entry,
    output logic                                 any_hit,
    output logic                                 position_overflow,
    output logic                                 run_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_WR_A,
        S_WR_B,
        S_EMIT_INS,
        S_EMIT_HIT,
        S_SUMMARY
    } state_t;

    state_t state_reg, state_next;

    // Read state.
    kwts_pkg::key_t                   window_reg, window_next;
    logic [kwts_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic [kwts_pkg::POS_W-1:0]       pos_reg, pos_next;
    kwts_pkg::slot_t                  first_reg, first_next;
    kwts_pkg::slot_t                  last_reg, last_next;
    logic                             seen_reg, seen_next;

    // Table bookkeeping.
    kwts_pkg::count_t                 entry_count_reg, entry_count_next;

    // Current request.
    logic                             is_insert_reg, is_insert_next;
    logic                             read_end_reg, read_end_next;
    kwts_pkg::key_t                   key_a_reg, key_a_next;
    kwts_pkg::key_t                   key_b_reg, key_b_next;
    logic [kwts_pkg::STEP_W-1:0]      issue_reg, issue_next;
    logic                             got_a_reg, got_a_next;
    kwts_pkg::slot_t                  slot_a_reg, slot_a_next;
    logic                             got_b_reg, got_b_next;
    kwts_pkg::slot_t                  slot_b_reg, slot_b_next;
    logic                             full_reg, full_next;
    kwts_pkg::slot_t                  ins_slot_reg, ins_slot_next;

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       kind_out_reg, kind_out_next;
    logic [kwts_pkg::INDEX_W-1:0]     index_out_reg, index_out_next;
    logic [kwts_pkg::WPOS_W-1:0]      wpos_out_reg, wpos_out_next;
    logic [kwts_pkg::INDEX_W-1:0]     first_out_reg, first_out_next;
    logic [kwts_pkg::INDEX_W-1:0]     final_out_reg, final_out_next;
    logic                             any_out_reg, any_out_next;
    logic                             ovf_out_reg, ovf_out_next;
    logic                             last_out_reg, last_out_next;

    // Cell row interface.
    kwts_pkg::rd_req_t                rd_req;
    kwts_pkg::wr_req_t                wr_req;
    kwts_pkg::chain_t                 chain [kwts_pkg::CELLS + 1];

    // Helpers.
    kwts_pkg::key_t                   fwd_key;
    kwts_pkg::key_t                   shifted;
    logic [kwts_pkg::FILL_W-1:0]      fill_inc;
    kwts_pkg::count_t                 ec_round;
    logic [kwts_pkg::STEP_W-1:0]      step_total;
    logic                             need_a;
    logic                             need_b;
    logic [kwts_pkg::COUNT_W:0]       need_total;
    logic                             out_free;
    logic [kwts_pkg::WPOS_W-1:0]      pos_clip;
    logic                             pos_ovf;
    logic [kwts_pkg::POS_W-1:0]       pos_inc;

    assign chain[0] = '0;

    // Each cell owns every eighth slot; the row scans one bank row per cycle.
    for (genvar c = 0; c < kwts_pkg::CELLS; c++)
    begin : g_cell
        kwts_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (kwts_pkg::LANE_W'(c)),
            .entry_count (entry_count_reg),
            .rd          (rd_req),
            .wr          (wr_req),
            .key_a       (key_a_reg),
            .key_b       (key_b_reg),
            .chain_in    (chain[c]),
            .chain_out   (chain[c+1])
        );
    end

    assign fwd_key  = kmer_value[kwts_pkg::KEY_W-1:0];
    assign shifted  = kwts_pkg::KEY_W'(window_reg << 2) | kwts_pkg::KEY_W'(base_code);
    assign fill_inc = (fill_reg < kwts_pkg::FILL_W'(kwts_pkg::KMER_LEN)) ?
                      fill_reg + 1'b1 : fill_reg;

    // Number of bank rows that hold at least one written slot.
    assign ec_round   = entry_count_reg + kwts_pkg::COUNT_W'(kwts_pkg::CELLS - 1);
    assign step_total = ec_round[kwts_pkg::COUNT_W-1:kwts_pkg::LANE_W];

    // An insert needs a slot for the forward k-mer if it is absent, and another for its
    // reverse complement if that is absent and not the same as the forward k-mer.
    assign need_a     = !got_a_reg;
    assign need_b     = !got_b_reg && (key_b_reg != key_a_reg);
    assign need_total = (kwts_pkg::COUNT_W+1)'(entry_count_reg)
                      + (kwts_pkg::COUNT_W+1)'(need_a)
                      + (kwts_pkg::COUNT_W+1)'(need_b);

    assign out_free = !out_valid_reg || out_ready;

    assign pos_clip = (pos_reg > kwts_pkg::POS_W'(kwts_pkg::WPOS_MAX)) ?
                      kwts_pkg::WPOS_W'(kwts_pkg::WPOS_MAX) : pos_reg[kwts_pkg::WPOS_W-1:0];
    assign pos_ovf  = (pos_reg >= kwts_pkg::POS_W'(kwts_pkg::WPOS_MAX));
    assign pos_inc  = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        window_next      = window_reg;
        fill_next        = fill_reg;
        pos_next         = pos_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        seen_next        = seen_reg;
        entry_count_next = entry_count_reg;
        is_insert_next   = is_insert_reg;
        read_end_next    = read_end_reg;
        key_a_next       = key_a_reg;
        key_b_next       = key_b_reg;
        issue_next       = issue_reg;
        got_a_next       = got_a_reg;
        slot_a_next      = slot_a_reg;
        got_b_next       = got_b_reg;
        slot_b_next      = slot_b_reg;
        full_next        = full_reg;
        ins_slot_next    = ins_slot_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        kind_out_next    = kind_out_reg;
        index_out_next   = index_out_reg;
        wpos_out_next    = wpos_out_reg;
        first_out_next   = first_out_reg;
        final_out_next   = final_out_reg;
        any_out_next     = any_out_reg;
        ovf_out_next     = ovf_out_reg;
        last_out_next    = last_out_reg;

        rd_req           = '0;
        wr_req           = '0;

        // Rows are compared in increasing order, so the first hit seen is the lowest slot.
        if (!got_a_reg && chain[kwts_pkg::CELLS].found_a)
        begin
            got_a_next  = 1'b1;
            slot_a_next = chain[kwts_pkg::CELLS].slot_a;
        end
        if (!got_b_reg && chain[kwts_pkg::CELLS].found_b)
        begin
            got_b_next  = 1'b1;
            slot_b_next = chain[kwts_pkg::CELLS].slot_b;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    read_end_next  = read_end;
                    is_insert_next = (kind == kwts_pkg::KIND_INSERT);
                    issue_next     = '0;
                    got_a_next     = 1'b0;
                    got_b_next     = 1'b0;
                    if (kind == kwts_pkg::KIND_INSERT)
                    begin
                        key_a_next = fwd_key;
                        key_b_next = kwts_pkg::revcomp(fwd_key);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        window_next = shifted;
                        fill_next   = fill_inc;
                        if (fill_inc == kwts_pkg::FILL_W'(kwts_pkg::KMER_LEN))
                        begin
                            key_a_next = shifted;
                            key_b_next = shifted;
                            state_next = S_SCAN;
                        end
                        else if (read_end)
                        begin
                            state_next = S_SUMMARY;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_reg != step_total)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = issue_reg[kwts_pkg::BANK_AW-1:0];
                    issue_next  = issue_reg + 1'b1;
                end
                else
                begin
                    // The last row's compare is captured at this edge.
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (is_insert_reg)
                begin
                    if (need_total > (kwts_pkg::COUNT_W+1)'(kwts_pkg::TABLE_SLOTS))
                    begin
                        full_next  = 1'b1;
                        state_next = S_EMIT_INS;
                    end
                    else
                    begin
                        full_next     = 1'b0;
                        ins_slot_next = got_a_reg ? slot_a_reg :
                                        entry_count_reg[kwts_pkg::SLOT_W-1:0];
                        state_next    = S_WR_A;
                    end
                end
                else if (got_a_reg)
                begin
                    state_next = S_EMIT_HIT;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = read_end_reg ? S_SUMMARY : S_IDLE;
                end
            end

            S_WR_A:
            begin
                if (need_a)
                begin
                    wr_req.en        = 1'b1;
                    wr_req.lane      = entry_count_reg[kwts_pkg::LANE_W-1:0];
                    wr_req.addr      = entry_count_reg[kwts_pkg::SLOT_W-1:kwts_pkg::LANE_W];
                    wr_req.key       = key_a_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                end
                state_next = S_WR_B;
            end

            S_WR_B:
            begin
                if (need_b)
                begin
                    wr_req.en        = 1'b1;
                    wr_req.lane      = entry_count_reg[kwts_pkg::LANE_W-1:0];
                    wr_req.addr      = entry_count_reg[kwts_pkg::SLOT_W-1:kwts_pkg::LANE_W];
                    wr_req.key       = key_b_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                end
                state_next = S_EMIT_INS;
            end

            S_EMIT_INS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_out_next  = full_reg ? kwts_pkg::RES_TABLE_FULL :
                                                kwts_pkg::RES_INSERT_OK;
                    index_out_next = full_reg ? '0 : kwts_pkg::INDEX_W'(ins_slot_reg);
                    wpos_out_next  = '0;
                    first_out_next = '0;
                    final_out_next = '0;
                    any_out_next   = 1'b0;
                    ovf_out_next   = 1'b0;
                    last_out_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_EMIT_HIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_out_next  = kwts_pkg::RES_HIT;
                    index_out_next = kwts_pkg::INDEX_W'(slot_a_reg);
                    wpos_out_next  = pos_clip;
                    first_out_next = '0;
                    final_out_next = '0;
                    any_out_next   = 1'b0;
                    ovf_out_next   = pos_ovf;
                    last_out_next  = !read_end_reg;
                    if (!seen_reg)
                    begin
                        first_next = slot_a_reg;
                    end
                    last_next  = slot_a_reg;
                    seen_next  = 1'b1;
                    pos_next   = pos_inc;
                    state_next = read_end_reg ? S_SUMMARY : S_IDLE;
                end
            end

            S_SUMMARY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_out_next  = kwts_pkg::RES_SUMMARY;
                    index_out_next = '0;
                    wpos_out_next  = '0;
                    first_out_next = kwts_pkg::INDEX_W'(first_reg);
                    final_out_next = kwts_pkg::INDEX_W'(last_reg);
                    any_out_next   = seen_reg;
                    ovf_out_next   = 1'b0;
                    last_out_next  = 1'b1;
                    // The read is over: start the next one from an empty window.
                    window_next    = '0;
                    fill_next      = '0;
                    pos_next       = '0;
                    first_next     = '0;
                    last_next      = '0;
                    seen_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_reg      <= '0;
            fill_reg        <= '0;
            pos_reg         <= '0;
            first_reg       <= '0;
            last_reg        <= '0;
            seen_reg        <= 1'b0;
            entry_count_reg <= '0;
            is_insert_reg   <= 1'b0;
            read_end_reg    <= 1'b0;
            key_a_reg       <= '0;
            key_b_reg       <= '0;
            issue_reg       <= '0;
            got_a_reg       <= 1'b0;
            slot_a_reg      <= '0;
            got_b_reg       <= 1'b0;
            slot_b_reg      <= '0;
            full_reg        <= 1'b0;
            ins_slot_reg    <= '0;
            out_valid_reg   <= 1'b0;
            kind_out_reg    <= '0;
            index_out_reg   <= '0;
            wpos_out_reg    <= '0;
            first_out_reg   <= '0;
            final_out_reg   <= '0;
            any_out_reg     <= 1'b0;
            ovf_out_reg     <= 1'b0;
            last_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_reg      <= window_next;
            fill_reg        <= fill_next;
            pos_reg         <= pos_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
            seen_reg        <= seen_next;
            entry_count_reg <= entry_count_next;
            is_insert_reg   <= is_insert_next;
            read_end_reg    <= read_end_next;
            key_a_reg       <= key_a_next;
            key_b_reg       <= key_b_next;
            issue_reg       <= issue_next;
            got_a_reg       <= got_a_next;
            slot_a_reg      <= slot_a_next;
            got_b_reg       <= got_b_next;
            slot_b_reg      <= slot_b_next;
            full_reg        <= full_next;
            ins_slot_reg    <= ins_slot_next;
            out_valid_reg   <= out_valid_next;
            kind_out_reg    <= kind_out_next;
            index_out_reg   <= index_out_next;
            wpos_out_reg    <= wpos_out_next;
            first_out_reg   <= first_out_next;
            final_out_reg   <= final_out_next;
            any_out_reg     <= any_out_next;
            ovf_out_reg     <= ovf_out_next;
            last_out_reg    <= last_out_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = kind_out_reg;
    assign entry_index       = index_out_reg;
    assign window_position   = wpos_out_reg;
    assign first_entry       = first_out_reg;
    assign final_entry       = final_out_reg;
    assign any_hit           = any_out_reg;
    assign position_overflow = ovf_out_reg;
    assign run_last          = last_out_reg;

endmodule

[hdl/kwts_cell.sv]
// One scan cell: a bank of table keys, a registered read and compare, and a link in the hit chain.
module kwts_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  kwts_pkg::lane_t         cell_id,
    input  kwts_pkg::count_t        entry_count,
    input  kwts_pkg::rd_req_t       rd,
    input  kwts_pkg::wr_req_t       wr,
    input  kwts_pkg::key_t          key_a,
    input  kwts_pkg::key_t          key_b,
    input  kwts_pkg::chain_t        chain_in,
    output kwts_pkg::chain_t        chain_out
);

    kwts_pkg::key_t  bank [kwts_pkg::BANK_DEPTH];
    kwts_pkg::key_t  rd_data_reg;
    kwts_pkg::slot_t slot_reg;
    logic            live_reg;
    logic            live_next;
    kwts_pkg::slot_t slot_issue;
    logic            hit_a;
    logic            hit_b;

    // Slots are interleaved across cells: the low bits pick the cell.
    assign slot_issue = {rd.addr, cell_id};
    assign live_next  = rd.en && ({1'b0, slot_issue} < entry_count);

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.lane == cell_id))
        begin
            bank[wr.addr] <= wr.key;
        end
        if (rd.en)
        begin
            rd_data_reg <= bank[rd.addr];
        end
        slot_reg <= slot_issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    assign hit_a = live_reg && (rd_data_reg == key_a);
    assign hit_b = live_reg && (rd_data_reg == key_b);

    // An earlier cell in the same step holds a lower slot, so it keeps priority.
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.found_a && hit_a)
        begin
            chain_out.found_a = 1'b1;
            chain_out.slot_a  = slot_reg;
        end
        if (!chain_in.found_b && hit_b)
        begin
            chain_out.found_b = 1'b1;
            chain_out.slot_b  = slot_reg;
        end
    end

endmodule

[tb/sv/kmer_window_table_scanner_test.sv]
// Self-checking testbench for the k-mer window table scanner with random handshake pacing.
`timescale 1ns / 1ps

module kmer_window_table_scanner_test;

    import kwts_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int LONG_HOLD    = 2000;
    localparam int DRAIN_CYCLES = 800;
    localparam int POS_TOP      = (1 << POSITION_BITS) - 1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One request as it goes onto the input channel.
    typedef struct packed {
        logic                    kind;
        logic [KMER_FIELD_W-1:0] kmer;
        logic [1:0]              base;
        logic                    last;
    } scan_request_t;

    // One result as the output channel should carry it.
    typedef struct packed {
        result_kind_t         kind;
        logic [INDEX_W-1:0]   idx;
        logic [WPOS_W-1:0]    wpos;
        logic [INDEX_W-1:0]   first;
        logic [INDEX_W-1:0]   fin;
        logic                 any;
        logic                 ovf;
        logic                 last;
    } scan_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    kind = KIND_INSERT;
    logic [KMER_FIELD_W-1:0] kmer_value = '0;
    logic [1:0]              base_code = 2'd0;
    logic                    read_end = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              result_kind;
    logic [INDEX_W-1:0]      entry_index;
    logic [WPOS_W-1:0]       window_position;
    logic [INDEX_W-1:0]      first_entry;
    logic [INDEX_W-1:0]      final_entry;
    logic                    any_hit;
    logic                    position_overflow;
    logic                    run_last;

    kmer_window_table_scanner dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .kmer_value        (kmer_value),
        .base_code         (base_code),
        .read_end          (read_end),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .entry_index       (entry_index),
        .window_position   (window_position),
        .first_entry       (first_entry),
        .final_entry       (final_entry),
        .any_hit           (any_hit),
        .position_overflow (position_overflow),
        .run_last          (run_last)
    );

    // Stimulus side: requests waiting for the driver, and the generator's own view of
    // which keys the table holds, in slot order.
    scan_request_t request_queue[$];
    scan_request_t offered;
    bit            known_key[key_t];
    key_t          known_list[$];
    int            items_queued = 0;

    // Pacing controls: the stimulus process sets the first three, the receiver owns the hold state.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_burst_id   = 0;
    int hold_seen_id    = 0;
    int hold_left       = 0;

    // Predicted scanner state.
    int           slot_of_key[key_t];
    int           entry_total = 0;
    key_t         shift_window = '0;
    int           bases_held = 0;
    int           window_start = 0;
    int           first_hit = 0;
    int           last_hit = 0;
    bit           read_hit = 1'b0;
    scan_result_t awaited_results[$];

    int error_count = 0;
    int cycle_count = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Reverse complement: walk the bases from the last one, complementing each.
    function automatic key_t flip_strand(input key_t k);
        key_t r;
        r = '0;
        for (int i = 0; i < KMER_LEN; i++)
        begin
            r = {r[KEY_W-3:0], ~k[1:0]};
            k = k >> 2;
        end
        return r;
    endfunction

    function automatic scan_result_t pack_result(input result_kind_t rk, input int idx,
                                                 input int pos, input int first,
                                                 input int fin, input bit any, input bit ovf);
        scan_result_t r;
        r.kind  = rk;
        r.idx   = idx[INDEX_W-1:0];
        r.wpos  = pos[WPOS_W-1:0];
        r.first = first[INDEX_W-1:0];
        r.fin   = fin[INDEX_W-1:0];
        r.any   = any;
        r.ovf   = ovf;
        r.last  = 1'b0;
        return r;
    endfunction

    // Works out the results of one accepted request and updates the predicted state.
    task automatic advance_scanner(input logic req_kind, input logic [KMER_FIELD_W-1:0] req_kmer,
                                   input logic [1:0] req_base, input logic req_last);
        scan_result_t res [2];
        int           n;
        int           need;
        int           s;
        int           p;
        key_t         fwd;
        key_t         rc;
        n = 0;
        if (req_kind == KIND_INSERT)
        begin
            fwd  = req_kmer[KEY_W-1:0];
            rc   = flip_strand(fwd);
            need = (slot_of_key.exists(fwd) ? 0 : 1)
                 + ((!slot_of_key.exists(rc) && rc != fwd) ? 1 : 0);
            if (entry_total + need > TABLE_SLOTS)
            begin
                // Neither strand goes in when both cannot.
                res[0] = pack_result(RES_TABLE_FULL, 0, 0, 0, 0, 1'b0, 1'b0);
            end
            else
            begin
                if (!slot_of_key.exists(fwd))
                begin
                    slot_of_key[fwd] = entry_total;
                    entry_total++;
                end
                if (!slot_of_key.exists(rc))
                begin
                    slot_of_key[rc] = entry_total;
                    entry_total++;
                end
                res[0] = pack_result(RES_INSERT_OK, slot_of_key[fwd], 0, 0, 0, 1'b0, 1'b0);
            end
            n = 1;
        end
        else
        begin
            shift_window = {shift_window[KEY_W-3:0], req_base};
            if (bases_held < KMER_LEN)
                bases_held++;
            if (bases_held >= KMER_LEN)
            begin
                if (slot_of_key.exists(shift_window))
                begin
                    s = slot_of_key[shift_window];
                    p = (window_start > WPOS_MAX) ? WPOS_MAX : window_start;
                    res[n] = pack_result(RES_HIT, s, p, 0, 0, 1'b0, window_start >= WPOS_MAX);
                    n++;
                    if (!read_hit)
                        first_hit = s;
                    last_hit = s;
                    read_hit = 1'b1;
                end
                if (window_start < POS_TOP)
                    window_start++;
            end
            if (req_last)
            begin
                res[n] = pack_result(RES_SUMMARY, 0, 0, first_hit, last_hit, read_hit, 1'b0);
                n++;
                shift_window = '0;
                bases_held   = 0;
                window_start = 0;
                first_hit    = 0;
                last_hit     = 0;
                read_hit     = 1'b0;
            end
        end
        if (n > 0)
        begin
            res[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                awaited_results = {awaited_results, res[i]};
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver: a request stays on the channel until it is taken; the next one may follow
    // in the cycle after it is taken unless the sender idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_scanner(kind, kmer_value, base_code, read_end);
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    offered    = request_queue.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= offered.kind;
                    kmer_value <= offered.kmer;
                    base_code  <= offered.base;
                    read_end   <= offered.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold each time the stimulus bumps the burst id.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_seen_id != hold_burst_id)
        begin
            hold_seen_id <= hold_burst_id;
            hold_left    <= LONG_HOLD;
            out_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: result_kind %0d entry_index %0d",
                       result_kind, entry_index);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(result_kind));
                check_field("entry_index", 64'(want.idx), 64'(entry_index));
                check_field("window_position", 64'(want.wpos), 64'(window_position));
                check_field("first_entry", 64'(want.first), 64'(first_entry));
                check_field("final_entry", 64'(want.fin), 64'(final_entry));
                check_field("any_hit", 64'(want.any), 64'(any_hit));
                check_field("position_overflow", 64'(want.ovf), 64'(position_overflow));
                check_field("run_last", 64'(want.last), 64'(run_last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[kmer_window_table_scanner] ERROR");
            $finish;
        end
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct = 79;
                recv_stall_pct  = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 79;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct = 12;
                recv_stall_pct  = 12;
            end
            default:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
        endcase
    endtask

    function automatic key_t rand_key();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KEY_W-1:0];
    endfunction

    // A k-mer equal to its own reverse complement.
    function automatic key_t palindrome_key();
        key_t       k;
        logic [1:0] b;
        k = '0;
        for (int i = 0; i < KMER_LEN / 2; i++)
        begin
            b = 2'($urandom_range(3, 0));
            k[2*(KMER_LEN-1-i) +: 2] = b;
            k[2*i +: 2]              = ~b;
        end
        return k;
    endfunction

    function automatic key_t novel_key();
        key_t k;
        k = rand_key();
        while (known_key.exists(k) || flip_strand(k) == k)
            k = rand_key();
        return k;
    endfunction

    function automatic key_t novel_palindrome();
        key_t k;
        k = palindrome_key();
        while (known_key.exists(k))
            k = palindrome_key();
        return k;
    endfunction

    task automatic push_request(input logic rk, input logic [KMER_FIELD_W-1:0] kv,
                                input logic [1:0] bc, input logic re);
        scan_request_t r;
        r.kind = rk;
        r.kmer = kv;
        r.base = bc;
        r.last = re;
        request_queue = {request_queue, r};
        items_queued++;
    endtask

    // Queues an insert and tracks which keys will be in the table, so reads can be
    // built to hit them. Unused fields of the request carry random values.
    task automatic queue_insert(input key_t k);
        key_t rc;
        int   need;
        rc   = flip_strand(k);
        need = (known_key.exists(k) ? 0 : 1) + ((!known_key.exists(rc) && rc != k) ? 1 : 0);
        if (known_list.size() + need <= TABLE_SLOTS)
        begin
            if (!known_key.exists(k))
            begin
                known_key[k] = 1'b1;
                known_list   = {known_list, k};
            end
            if (!known_key.exists(rc))
            begin
                known_key[rc] = 1'b1;
                known_list    = {known_list, rc};
            end
        end
        push_request(KIND_INSERT, k, 2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
    endtask

    task automatic queue_random_insert();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55 || known_list.size() == 0)
            queue_insert(rand_key());
        else if (r < 75)
            queue_insert(palindrome_key());
        else
            queue_insert(known_list[$urandom_range(known_list.size() - 1, 0)]);
    endtask

    // Queues one read of random bases with known keys written into it. With near_limit
    // the keys sit around the point where the window position saturates.
    task automatic queue_read(input int len, input int embeds, input int min_slot,
                              input bit near_limit);
        logic [1:0] seq[];
        key_t       k;
        int         off;
        int         lo;
        seq = new[len];
        for (int i = 0; i < len; i++)
            seq[i] = 2'($urandom_range(3, 0));
        lo = (min_slot < known_list.size()) ? min_slot : 0;
        for (int e = 0; e < embeds; e++)
        begin
            if (known_list.size() > 0 && len >= KMER_LEN)
            begin
                k = known_list[$urandom_range(known_list.size() - 1, lo)];
                if (near_limit)
                    off = (e == 0) ? 224 : (e == 1) ? 254 + $urandom_range(2, 0) : len - KMER_LEN;
                else if ($urandom_range(2, 0) == 0)
                    off = len - KMER_LEN;
                else
                    off = $urandom_range(len - KMER_LEN, 0);
                for (int i = 0; i < KMER_LEN; i++)
                    seq[off + i] = k[2*(KMER_LEN-1-i) +: 2];
            end
        end
        for (int i = 0; i < len; i++)
        begin
            // An occasional insert lands in the middle of the read.
            if (i > 0 && $urandom_range(49, 0) == 0)
                queue_random_insert();
            push_request(KIND_BASE, rand_key(), seq[i], i == len - 1);
        end
    endtask

    task automatic wait_results_done();
        while (request_queue.size() > 0 || in_valid || awaited_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic wait_queue_empty();
        while (request_queue.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int round;
        int round_end;
        int r;
        int len;
        int n;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reads before any insert, duplicates in both strand orders, palindromes.
        set_idle_mode(IDLE_NONE);
        push_request(KIND_BASE, '1, 2'd3, 1'b1);
        queue_read(2, 0, 0, 1'b0);
        queue_insert('0);
        queue_insert('1);
        queue_insert('0);
        queue_insert(60'h000_0000_3FFF_FFFF);
        queue_insert(palindrome_key());
        queue_insert(60'hA5A_5A5A_5A5A_5A5A);
        queue_insert(rand_key());
        queue_insert(rand_key());
        wait_results_done();

        // Mixed reads and inserts against a small table; one long read runs the
        // position counter into saturation.
        round = 0;
        while (items_queued < 500)
        begin
            wait_queue_empty();
            set_idle_mode(idle_mode_t'(round % 4));
            if (round == 3)
                hold_burst_id++;
            if (round == 2)
                wait_results_done();
            if (round == 1)
                queue_read($urandom_range(330, 290), 3, 0, 1'b1);
            round_end = items_queued + 30;
            while (items_queued < round_end)
            begin
                if ($urandom_range(99, 0) < 45)
                begin
                    queue_random_insert();
                end
                else
                begin
                    r = $urandom_range(99, 0);
                    if (r < 20)
                        len = $urandom_range(KMER_LEN - 1, 1);
                    else if (r < 35)
                        len = KMER_LEN;
                    else
                        len = $urandom_range(KMER_LEN + 30, KMER_LEN + 1);
                    queue_read(len, $urandom_range(2, 0), 0, 1'b0);
                end
            end
            round++;
        end

        // Fill the table to its last slots, with a few reads along the way.
        n = 0;
        while (known_list.size() < TABLE_SLOTS - 2)
        begin
            if (n % 100 == 0)
            begin
                wait_queue_empty();
                set_idle_mode(idle_mode_t'((n / 100) % 4));
                queue_read($urandom_range(KMER_LEN - 1, 1), 0, 0, 1'b0);
                if (n % 300 == 0)
                    queue_read(KMER_LEN + 1, 1, 0, 1'b0);
            end
            queue_insert(novel_key());
            n++;
        end
        if (known_list.size() == TABLE_SLOTS - 2)
            queue_insert(novel_palindrome());
        // One slot left: a two-strand insert is refused, a palindrome still fits.
        queue_insert(novel_key());
        queue_insert(novel_palindrome());
        // Table full: only duplicates are still answered as inserted.
        queue_insert(novel_key());
        queue_insert(novel_palindrome());
        queue_insert(known_list[0]);
        queue_insert(known_list[TABLE_SLOTS - 1]);

        // Reads against the full table, hitting the upper slots.
        for (round = 0; round < 4; round++)
        begin
            wait_queue_empty();
            set_idle_mode(idle_mode_t'(round));
            queue_read(KMER_LEN + 5, 2, TABLE_SLOTS / 2, 1'b0);
            queue_random_insert();
        end
        queue_read(KMER_LEN, 1, 0, 1'b0);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("[kmer_window_table_scanner] OK");
        else
            $display("[kmer_window_table_scanner] ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/kwts_pkg.sv
hdl/kwts_cell.sv
hdl/kmer_window_table_scanner.sv
tb/sv/kmer_window_table_scanner_test.sv
